// ===== design/dmm_pkg.sv =====
// Shared types and constants of the density multipole moment block.
`default_nettype none

package dmm_pkg;

   // Field widths of one quadrature point and one moment
   localparam int DENS_W = 32;
   localparam int WGT_W  = 32;
   localparam int POS_W  = 24;
   localparam int ORD_W  = 2;
   localparam int IDX_W  = 4;
   localparam int SUM_W  = 64;

   // Stream payload widths (whole bytes)
   localparam int REQ_DATA_W = 136;
   localparam int RSP_DATA_W = 72;

   // Moment order codes
   localparam logic [ORD_W-1:0] ORDER_MONO   = 2'd0;
   localparam logic [ORD_W-1:0] ORDER_DIPOLE = 2'd1;
   localparam logic [ORD_W-1:0] ORDER_QUAD   = 2'd2;
   localparam logic [ORD_W-1:0] ORDER_RESET  = ORDER_QUAD;

   // One classified point as it waits between front and back
   typedef struct packed {
      logic [DENS_W-1:0] density;
      logic [WGT_W-1:0]  weight;
      logic [POS_W-1:0]  pos_x;
      logic [POS_W-1:0]  pos_y;
      logic [POS_W-1:0]  pos_z;
      logic              last_point;
      logic [ORD_W-1:0]  order;
   } dmm_item_type;

endpackage

`default_nettype wire

// ===== design/dmm_queue.sv =====
// Two-entry queue that decouples point intake from moment accumulation.
`default_nettype none

module dmm_queue
   import dmm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push_valid,
   output logic              push_ready,
   input  wire dmm_item_type push_item,
   output logic              pop_valid,
   input  wire logic         pop_ready,
   output dmm_item_type      pop_item
);

   dmm_item_type entry_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         do_push, do_pop;

   // Flow control
   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== design/dmm_front.sv =====
// Intake side: order register and classification of incoming points.
`default_nettype none

module dmm_front
   import dmm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tlast,
   input  wire logic                  csr_wr_en,
   input  wire logic [ORD_W-1:0]      csr_wr_data,
   output logic                       push_valid,
   input  wire logic                  push_ready,
   output dmm_item_type               push_item
);

   logic [ORD_W-1:0] order_ff, order_in;

   // Hold the configured order
   always_comb begin
      order_in = csr_wr_en ? csr_wr_data : order_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= ORDER_RESET;
      end else begin
         order_ff <= order_in;
      end
   end

   // Unpack the point and tag it with the order in force; order three acts as two
   always_comb begin
      push_item.density    = req_tdata[31:0];
      push_item.weight     = req_tdata[63:32];
      push_item.pos_x      = req_tdata[87:64];
      push_item.pos_y      = req_tdata[111:88];
      push_item.pos_z      = req_tdata[135:112];
      push_item.last_point = req_tlast;
      push_item.order      = (order_ff >= ORDER_QUAD) ? ORDER_QUAD : order_ff;
   end

   assign push_valid = req_tvalid;
   assign req_tready = push_ready;

endmodule

`default_nettype wire

// ===== design/dmm_back.sv =====
// Accumulation side: shared split multiplier, moment sums and result emission.
`default_nettype none

module dmm_back
   import dmm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  pop_valid,
   output logic                       pop_ready,
   input  wire dmm_item_type          pop_item,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tlast
);

   localparam int NUM_SUMS = 10;
   localparam int NUM_T    = 6;
   localparam int OP_W     = 50;
   localparam int PART_W   = 25;
   localparam int PROD_W   = 52;
   localparam int ACC_W    = 100;
   localparam int RW_W     = 49;

   localparam logic [3:0] LAST_OP_MONO   = 4'd0;
   localparam logic [3:0] LAST_OP_DIPOLE = 4'd3;
   localparam logic [3:0] LAST_OP_QUAD   = 4'd15;
   localparam logic [3:0] LAST_K_MONO    = 4'd0;
   localparam logic [3:0] LAST_K_DIPOLE  = 4'd3;
   localparam logic [3:0] LAST_K_QUAD    = 4'd12;
   localparam logic [2:0] PH_WRITE       = 3'd5;
   localparam logic [2:0] PH_ADD         = 3'd6;

   localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_EMIT} state_type;
   typedef enum logic [1:0] {OP_RW, OP_DIP, OP_COORD, OP_QUAD} op_kind_type;

   // Operation schedule: 0 rw, 1-3 dipole, 4-9 coordinate products
   // (xx, yy, zz, xy, xz, yz), 10-15 quadrupole terms
   function automatic op_kind_type op_kind(input logic [3:0] op);
      op_kind_type k;
      priority if (op == 4'd0) k = OP_RW;
      else if (op <= 4'd3)     k = OP_DIP;
      else if (op <= 4'd9)     k = OP_COORD;
      else                     k = OP_QUAD;
      return k;
   endfunction

   function automatic logic [1:0] coord_a(input logic [3:0] op);
      logic [1:0] c;
      unique case (op)
         4'd5, 4'd9: c = 2'd1;
         4'd6:       c = 2'd2;
         default:    c = 2'd0;
      endcase
      return c;
   endfunction

   function automatic logic [1:0] coord_b(input logic [3:0] op);
      logic [1:0] c;
      unique case (op)
         4'd2, 4'd5, 4'd7:       c = 2'd1;
         4'd3, 4'd6, 4'd8, 4'd9: c = 2'd2;
         default:                c = 2'd0;
      endcase
      return c;
   endfunction

   function automatic logic [3:0] sum_dest(input logic [3:0] op);
      logic [3:0] d;
      priority if (op <= 4'd3) d = op;
      else                     d = op - 4'd6;
      return d;
   endfunction

   // Emitted index to sum slot: row-major 3x3 folds onto six unique sums
   function automatic logic [3:0] emit_map(input logic [3:0] k);
      logic [3:0] s;
      unique case (k)
         4'd7:         s = 4'd5;
         4'd8:         s = 4'd7;
         4'd9:         s = 4'd8;
         4'd10:        s = 4'd6;
         4'd11:        s = 4'd8;
         4'd12:        s = 4'd9;
         default:      s = k;
      endcase
      return s;
   endfunction

   function automatic logic [2:0] diag_slot(input logic [1:0] c);
      logic [2:0] s;
      unique case (c)
         2'd1:    s = 3'd3;
         2'd2:    s = 3'd5;
         default: s = 3'd0;
      endcase
      return s;
   endfunction

   function automatic logic [2:0] cross_slot(input logic [3:0] op);
      logic [2:0] s;
      unique case (op)
         4'd8:    s = 3'd2;
         4'd9:    s = 3'd4;
         default: s = 3'd1;
      endcase
      return s;
   endfunction

   function automatic logic [SUM_W-1:0] sat64(input logic [ACC_W-1:0] v);
      logic [SUM_W-1:0] r;
      if ((&v[ACC_W-1:SUM_W-1]) || !(|v[ACC_W-1:SUM_W-1])) begin
         r = v[SUM_W-1:0];
      end else begin
         r = v[ACC_W-1] ? SUM_MIN : SUM_MAX;
      end
      return r;
   endfunction

   function automatic logic [SUM_W-1:0] add_sat(input logic [SUM_W-1:0] a,
                                                input logic [SUM_W-1:0] b);
      logic [SUM_W:0]   s;
      logic [SUM_W-1:0] r;
      s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
      if (s[SUM_W] != s[SUM_W-1]) begin
         r = s[SUM_W] ? SUM_MIN : SUM_MAX;
      end else begin
         r = s[SUM_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [OP_W-1:0] pos_ext(input dmm_item_type it,
                                               input logic [1:0] c);
      logic [POS_W-1:0] p;
      unique case (c)
         2'd1:    p = it.pos_y;
         2'd2:    p = it.pos_z;
         default: p = it.pos_x;
      endcase
      return {{(OP_W-POS_W){p[POS_W-1]}}, p};
   endfunction

   state_type          state_ff, state_in;
   dmm_item_type       cur_ff, cur_in;
   logic [3:0]         op_ff, op_in;
   logic [2:0]         phase_ff, phase_in;
   logic [3:0]         emit_k_ff, emit_k_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [1:0]         prod_part_ff, prod_part_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [SUM_W-1:0]   term_ff, term_in;
   logic [RW_W-1:0]    rw_ff, rw_in;
   logic [OP_W-1:0]    treg_ff [NUM_T];
   logic [OP_W-1:0]    treg_in [NUM_T];
   logic [SUM_W-1:0]   sum_ff [NUM_SUMS];
   logic [SUM_W-1:0]   sum_in [NUM_SUMS];
   logic               rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]   rsp_idx_ff, rsp_idx_in;
   logic [SUM_W-1:0]   rsp_value_ff, rsp_value_in;
   logic               rsp_last_ff, rsp_last_in;

   op_kind_type        kind;
   logic [3:0]         last_op;
   logic [3:0]         last_k;
   logic [3:0]         rd_idx;
   logic [SUM_W-1:0]   sum_rd;
   logic [OP_W-1:0]    opa, opb;
   logic signed [PART_W:0] part_a, part_b;
   logic [ACC_W-1:0]   prod_ext, addend;
   logic [OP_W-1:0]    cprod;
   logic [3:0]         dest;
   logic               load_out;
   logic               out_last;

   // Decode the current operation
   assign kind = op_kind(op_ff);
   assign dest = sum_dest(op_ff);

   always_comb begin
      unique case (cur_ff.order)
         ORDER_MONO: begin
            last_op = LAST_OP_MONO;
            last_k  = LAST_K_MONO;
         end
         ORDER_DIPOLE: begin
            last_op = LAST_OP_DIPOLE;
            last_k  = LAST_K_DIPOLE;
         end
         default: begin
            last_op = LAST_OP_QUAD;
            last_k  = LAST_K_QUAD;
         end
      endcase
   end

   // Single read port on the sums, shared by accumulate and emission
   assign rd_idx = (state_ff == ST_EMIT) ? emit_map(emit_k_ff) : dest;
   assign sum_rd = sum_ff[rd_idx];

   // Select multiplier operands for the current operation
   always_comb begin
      unique case (kind)
         OP_RW: begin
            opa = {{(OP_W-DENS_W){cur_ff.density[DENS_W-1]}}, cur_ff.density};
            opb = {{(OP_W-WGT_W){1'b0}}, cur_ff.weight};
         end
         OP_DIP: begin
            opa = {rw_ff[RW_W-1], rw_ff};
            opb = pos_ext(cur_ff, coord_b(op_ff));
         end
         OP_COORD: begin
            opa = pos_ext(cur_ff, coord_a(op_ff));
            opb = pos_ext(cur_ff, coord_b(op_ff));
         end
         default: begin
            opa = {rw_ff[RW_W-1], rw_ff};
            opb = treg_ff[3'(op_ff - 4'd10)];
         end
      endcase
   end

   // Pick the partial product halves: low halves unsigned, high halves signed
   always_comb begin
      if (phase_ff[1]) begin
         part_a = {opa[OP_W-1], opa[OP_W-1:PART_W]};
      end else begin
         part_a = {1'b0, opa[PART_W-1:0]};
      end
      if (phase_ff[0]) begin
         part_b = {opb[OP_W-1], opb[OP_W-1:PART_W]};
      end else begin
         part_b = {1'b0, opb[PART_W-1:0]};
      end
   end

   // Align the registered partial product
   always_comb begin
      prod_ext = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      unique case (prod_part_ff)
         2'd0:       addend = prod_ext;
         2'd3:       addend = prod_ext << (2 * PART_W);
         default:    addend = prod_ext << PART_W;
      endcase
   end

   assign cprod = acc_ff[OP_W-1:0];

   // Next-state logic
   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      op_in         = op_ff;
      phase_in      = phase_ff;
      emit_k_in     = emit_k_ff;
      prod_in       = prod_ff;
      prod_part_in  = prod_part_ff;
      acc_in        = acc_ff;
      term_in       = term_ff;
      rw_in         = rw_ff;
      treg_in       = treg_ff;
      sum_in        = sum_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      pop_ready     = 1'b0;
      load_out      = 1'b0;
      out_last      = 1'b0;

      // Drop a transferred result
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               pop_ready = 1'b1;
               cur_in    = pop_item;
               op_in     = 4'd0;
               phase_in  = 3'd0;
               for (int i = 0; i < NUM_T; i++) begin
                  treg_in[i] = '0;
               end
               state_in  = ST_RUN;
            end
         end
         ST_RUN: begin
            // Issue one partial product a cycle
            if (phase_ff <= 3'd3) begin
               prod_in      = PROD_W'(part_a) * PROD_W'(part_b);
               prod_part_in = phase_ff[1:0];
            end
            // Accumulate the previous partial
            if (phase_ff >= 3'd1 && phase_ff <= 3'd4) begin
               acc_in = ((phase_ff == 3'd1) ? '0 : acc_ff) + addend;
            end
            // Scale the full product
            if (phase_ff == PH_WRITE) begin
               unique case (kind)
                  OP_RW: begin
                     term_in = sat64(ACC_W'($signed(acc_ff) >>> 16));
                     rw_in   = acc_ff[RW_W+15:16];
                  end
                  OP_DIP: begin
                     term_in = sat64(ACC_W'($signed(acc_ff) >>> 12));
                  end
                  OP_QUAD: begin
                     term_in = sat64(ACC_W'($signed(acc_ff) >>> 24));
                  end
                  default: begin
                     // Build the traceless terms from the coordinate products
                     if (op_ff <= 4'd6) begin
                        for (int c = 0; c < 3; c++) begin
                           if (2'(c) == 2'(op_ff - 4'd4)) begin
                              treg_in[diag_slot(2'(c))] =
                                 treg_ff[diag_slot(2'(c))] + (cprod << 1);
                           end else begin
                              treg_in[diag_slot(2'(c))] =
                                 treg_ff[diag_slot(2'(c))] - cprod;
                           end
                        end
                     end else begin
                        treg_in[cross_slot(op_ff)] = cprod + (cprod << 1);
                     end
                  end
               endcase
            end
            // Add the term into its sum and advance the schedule
            if (phase_ff == PH_ADD) begin
               if (kind != OP_COORD) begin
                  sum_in[dest] = add_sat(sum_rd, term_ff);
               end
               phase_in = 3'd0;
               if (op_ff == last_op) begin
                  emit_k_in = 4'd0;
                  state_in  = cur_ff.last_point ? ST_EMIT : ST_IDLE;
               end else begin
                  op_in = op_ff + 4'd1;
               end
            end else begin
               phase_in = phase_ff + 3'd1;
            end
         end
         default: begin
            // Emit one moment per free output slot
            if (!rsp_valid_ff || rsp_tready) begin
               load_out     = 1'b1;
               out_last     = (emit_k_ff == last_k);
               rsp_valid_in = 1'b1;
               rsp_idx_in   = emit_k_ff;
               rsp_value_in = sum_rd;
               rsp_last_in  = out_last;
               if (out_last) begin
                  for (int i = 0; i < NUM_SUMS; i++) begin
                     sum_in[i] = '0;
                  end
                  state_in = ST_IDLE;
               end else begin
                  emit_k_in = emit_k_ff + 4'd1;
               end
            end
         end
      endcase
   end

   // Control state, sums and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= 4'd0;
         phase_ff     <= 3'd0;
         emit_k_ff    <= 4'd0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_SUMS; i++) begin
            sum_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         phase_ff     <= phase_in;
         emit_k_ff    <= emit_k_in;
         rsp_valid_ff <= rsp_valid_in;
         sum_ff       <= sum_in;
      end
   end

   // Datapath and result payload
   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      prod_ff      <= prod_in;
      prod_part_ff <= prod_part_in;
      acc_ff       <= acc_in;
      term_ff      <= term_in;
      rw_ff        <= rw_in;
      treg_ff      <= treg_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-SUM_W-IDX_W){1'b0}}, rsp_value_ff, rsp_idx_ff};
   assign rsp_tlast  = rsp_last_ff;

   // The schedule never runs past the last operation of the order in force
   a_run_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (phase_ff <= PH_ADD && op_ff <= last_op))
      else $error("operation schedule out of range");

   // Emission never runs past the last moment of the order
   a_emit_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (emit_k_ff <= last_k))
      else $error("emission index out of range");

   // The final moment clears every sum and frees the back end
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (load_out && out_last) |=> (state_ff == ST_IDLE && sum_ff[0] == '0
                                  && sum_ff[9] == '0 && rsp_tlast))
      else $error("sums not cleared after the final moment");

   // A point that is not last produces no moments
   a_no_emit_mid_pass: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && phase_ff == PH_ADD && op_ff == last_op
       && !cur_ff.last_point) |=> (state_ff == ST_IDLE))
      else $error("moments emitted for a point that is not last");

endmodule

`default_nettype wire

// ===== design/density_multipole_moments.sv =====
// Top level of the density multipole moment block: intake, queue and accumulator.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+---------------------------------------
//   req     | in        | req_tvalid/tready   | tdata: density, weight, x, y, z; tlast
//   rsp     | out       | rsp_tvalid/tready   | tdata: moment_index, moment_value; tlast
//   csr     | in        | csr_wr_en           | csr_wr_data: max_order
//
// Each point runs as a schedule of products on one shared 26x26 multiplier; each
// product runs as four partials, accumulate, scale and saturating add, in that order.
// A point runs N = 1, 4 or 16 products for order 0, 1 or 2, and a last point then
// emits 1, 4 or 13 moments, one moment per free slot of the output register.
// Reset (synchronous, active high) clears the sums, sets max_order to 2 and
// empties the two-entry queue. req_tready drops only while the queue is full;
// a stalled result holds in the output register while the accumulator goes on.
`default_nettype none

module density_multipole_moments
   import dmm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // density[31:0], weight[63:32], pos_x[87:64], pos_y[111:88], pos_z[135:112]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tlast,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // moment_index[3:0], moment_value[67:4], zero fill[71:68]
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tlast,
   input  wire logic                  csr_wr_en,
   input  wire logic [ORD_W-1:0]      csr_wr_data
);

   logic         push_valid, push_ready;
   dmm_item_type push_item;
   logic         pop_valid, pop_ready;
   dmm_item_type pop_item;

   // Accept and classify points
   dmm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_item   (push_item)
   );

   // Buffer points between intake and accumulation
   dmm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   // Accumulate moments and emit them on the last point
   dmm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== verif/tb_density_multipole_moments.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the density multipole moment block: driver, monitor, predictor.
module tb_density_multipole_moments;
   import dmm_pkg::*;

   localparam int RANDOM_POINTS = 460;
   // two queued points plus one in work at quadrupole order, then emission
   localparam int DRAIN_CYCLES  = 400;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int PRINT_LIMIT   = 100;
   localparam int NUM_SUMS      = 10;
   // order code 3 decodes as quadrupole
   localparam logic [ORD_W-1:0] ORDER_ALIAS = 2'd3;
   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   typedef struct {
      logic signed [DENS_W-1:0] density;
      logic [WGT_W-1:0]         weight;
      logic signed [POS_W-1:0]  pos_x;
      logic signed [POS_W-1:0]  pos_y;
      logic signed [POS_W-1:0]  pos_z;
      logic                     last_point;
   } point_type;

   typedef struct {
      logic [IDX_W-1:0]        index;
      logic signed [SUM_W-1:0] value;
      logic                    last_moment;
   } moment_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic                  req_tlast   = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_wr_en   = 1'b0;
   logic [ORD_W-1:0]      csr_wr_data = '0;

   // predictor state
   logic signed [SUM_W-1:0] moment_sum [NUM_SUMS];
   logic [ORD_W-1:0]        order_in_force;

   point_type  pending_points [$];
   moment_type expected_moments [$];
   point_type  cur_point;
   int      points_queued   = 0;
   int      points_accepted = 0;
   int      burst_left      = 0;
   int      gap_left        = 0;
   int      error_count     = 0;
   int      cycle_count     = 0;
   logic [7:0] stall_pattern = '1;
   logic [2:0] stall_phase   = '0;

   density_multipole_moments DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #1 clock = ~clock;

   task automatic report_mismatch(string what);
      if (error_count < PRINT_LIMIT)
         $display("MISMATCH cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   // floor(a*b / 2^shift), clamped to the signed sum range
   function automatic logic signed [SUM_W-1:0] scaled_product(logic signed [127:0] a,
                                                               logic signed [127:0] b,
                                                               int unsigned shift);
      logic signed [127:0] full;
      full = (a * b) >>> shift;
      if (full[127:SUM_W-1] != {(129-SUM_W){full[127]}})
         return full[127] ? SUM_MIN : SUM_MAX;
      return full[SUM_W-1:0];
   endfunction

   function automatic logic signed [SUM_W-1:0] sat_add(logic signed [SUM_W-1:0] a,
                                                        logic signed [SUM_W-1:0] b);
      logic signed [SUM_W:0] s;
      s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
      if (s[SUM_W] != s[SUM_W-1])
         return s[SUM_W] ? SUM_MIN : SUM_MAX;
      return s[SUM_W-1:0];
   endfunction

   // Fold one point into the sums; on the last point queue the moments and clear.
   function automatic void accumulate_point(point_type pt);
      logic signed [SUM_W-1:0] rw, r2, t;
      logic signed [SUM_W-1:0] coord [3];
      logic [ORD_W-1:0]        eff_order;
      moment_type              m;
      int                      total, slot, row, col, lo, hi;
      eff_order = (order_in_force > ORDER_QUAD) ? ORDER_QUAD : order_in_force;
      coord[0] = SUM_W'(pt.pos_x);
      coord[1] = SUM_W'(pt.pos_y);
      coord[2] = SUM_W'(pt.pos_z);
      rw = scaled_product(128'(pt.density), 128'({1'b0, pt.weight}), 16);
      moment_sum[0] = sat_add(moment_sum[0], rw);
      if (eff_order >= ORDER_DIPOLE) begin
         for (int k = 0; k < 3; k++)
            moment_sum[1+k] = sat_add(moment_sum[1+k],
                                      scaled_product(128'(rw), 128'(coord[k]), 12));
      end
      if (eff_order == ORDER_QUAD) begin
         r2 = coord[0] * coord[0] + coord[1] * coord[1] + coord[2] * coord[2];
         slot = 4;
         for (int i = 0; i < 3; i++) begin
            for (int j = i; j < 3; j++) begin
               t = 64'sd3 * coord[i] * coord[j];
               if (i == j)
                  t = t - r2;
               moment_sum[slot] = sat_add(moment_sum[slot],
                                          scaled_product(128'(rw), 128'(t), 24));
               slot++;
            end
         end
      end
      if (!pt.last_point)
         return;
      total = (eff_order == ORDER_MONO) ? 1 : ((eff_order == ORDER_DIPOLE) ? 4 : 13);
      for (int k = 0; k < total; k++) begin
         if (k < 4) begin
            slot = k;
         end else begin
            // map row-major 3x3 onto the upper triangle
            row  = (k - 4) / 3;
            col  = (k - 4) % 3;
            lo   = (row < col) ? row : col;
            hi   = (row < col) ? col : row;
            slot = 4 + lo * 3 - lo * (lo - 1) / 2 + (hi - lo);
         end
         m.index       = IDX_W'(k);
         m.value       = moment_sum[slot];
         m.last_moment = (k == total - 1);
         expected_moments.push_back(m);
      end
      foreach (moment_sum[s])
         moment_sum[s] = '0;
   endfunction

   // Random field pattern: extremes, zero, small magnitudes or raw bits.
   function automatic logic [31:0] pick_bits(int unsigned w);
      logic [31:0] mask, v;
      mask = (w == 32) ? '1 : (32'd1 << w) - 32'd1;
      case ($urandom_range(0, 9))
         0: v = $urandom;
         1: v = mask >> 1;
         2: v = ~(mask >> 1);
         3: v = '0;
         4: v = '1;
         default: begin
            v = $urandom >> $urandom_range(w / 2, 31);
            if ($urandom_range(0, 1) == 1)
               v = -v;
         end
      endcase
      return v & mask;
   endfunction

   task automatic send_point(logic [31:0] d, logic [31:0] w, logic [31:0] x,
                             logic [31:0] y, logic [31:0] z, logic last);
      point_type pt;
      pt.density    = d[DENS_W-1:0];
      pt.weight     = w[WGT_W-1:0];
      pt.pos_x      = x[POS_W-1:0];
      pt.pos_y      = y[POS_W-1:0];
      pt.pos_z      = z[POS_W-1:0];
      pt.last_point = last;
      pending_points.push_back(pt);
      points_queued++;
   endtask

   // Wait until every point is taken, every moment is back and the pipe is empty.
   task automatic settle();
      while (points_accepted != points_queued)
         @(posedge clock);
      while (expected_moments.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_order(logic [ORD_W-1:0] value);
      settle();
      @(posedge clock);
      csr_wr_en      <= 1'b1;
      csr_wr_data    <= value;
      order_in_force  = value;
      @(posedge clock);
      csr_wr_en      <= 1'b0;
   endtask

   // Driver: predict each accepted transfer, present points in bursts with gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            accumulate_point(cur_point);
            points_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_points.size() > 0) begin
               cur_point   = pending_points.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {cur_point.pos_z, cur_point.pos_y, cur_point.pos_x,
                              cur_point.weight, cur_point.density};
               req_tlast  <= cur_point.last_point;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 24);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each moment transfer, stall on a rolling random pattern.
   always @(posedge clock) begin
      moment_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_moments.size() == 0) begin
               report_mismatch($sformatf("moment %0d arrived with none expected",
                                         rsp_tdata[IDX_W-1:0]));
            end else begin
               want = expected_moments.pop_front();
               if (rsp_tdata[IDX_W-1:0] !== want.index)
                  report_mismatch($sformatf("moment_index got %0d want %0d",
                                            rsp_tdata[IDX_W-1:0], want.index));
               if ($signed(rsp_tdata[IDX_W +: SUM_W]) !== want.value)
                  report_mismatch($sformatf("moment %0d value got %0d want %0d", want.index,
                                            $signed(rsp_tdata[IDX_W +: SUM_W]), want.value));
               if (rsp_tlast !== want.last_moment)
                  report_mismatch($sformatf("moment %0d last got %0b want %0b", want.index,
                                            rsp_tlast, want.last_moment));
            end
         end
         if (stall_phase == 3'd0)
            stall_pattern = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom);
         rsp_tready  <= stall_pattern[stall_phase];
         stall_phase  = stall_phase + 3'd1;
      end
   end

   // Hold a hard ceiling on run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int pass_len, split, random_points;
      order_in_force = ORDER_RESET;
      foreach (moment_sum[s])
         moment_sum[s] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset order: lone all-zero last point, then a pass driven into saturation
      send_point(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1);
      send_point(32'h0001_0000, 32'h0001_0000, 32'h0000_1000, 32'h00FF_E000,
                 32'h0000_0800, 1'b0);
      send_point(32'hFFFF_8000, 32'h0002_0000, 32'h0000_3000, 32'h0, 32'h00FF_F000, 1'b0);
      send_point(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h007F_FFFF, 32'h007F_FFFF,
                 32'h007F_FFFF, 1'b0);
      send_point(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h007F_FFFF, 32'h007F_FFFF,
                 32'h007F_FFFF, 1'b0);
      send_point(32'h8000_0000, 32'hFFFF_FFFF, 32'h0080_0000, 32'h007F_FFFF,
                 32'h0080_0000, 1'b1);

      // Monopole only, with a tiny negative product that floors to -1
      write_order(ORDER_MONO);
      send_point(32'h8000_0000, 32'hFFFF_FFFF, 32'h007F_FFFF, 32'h0, 32'h0, 1'b0);
      send_point(32'h8000_0000, 32'hFFFF_FFFF, 32'h0080_0000, 32'h0, 32'h0, 1'b0);
      send_point(32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_1000, 32'h0, 32'h0, 1'b1);

      write_order(ORDER_DIPOLE);
      send_point(32'h0001_0000, 32'h0001_0000, 32'h0080_0000, 32'h007F_FFFF,
                 32'h00FF_FFFF, 1'b0);
      send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 32'h00FF_FFFF,
                 32'h0080_0000, 1'b1);

      write_order(ORDER_ALIAS);
      send_point(32'h0001_0000, 32'h0001_0000, 32'h0000_1000, 32'h0000_1000,
                 32'h0000_1000, 1'b1);

      // Drop the order mid-pass; higher sums must still clear at the end
      write_order(ORDER_QUAD);
      send_point(32'h0003_0000, 32'h0001_0000, 32'h0000_2000, 32'h00FF_F000,
                 32'h0000_3000, 1'b0);
      send_point(32'h0002_0000, 32'h0000_8000, 32'h00FF_D000, 32'h0000_1000,
                 32'h0, 1'b0);
      write_order(ORDER_MONO);
      send_point(32'h0001_0000, 32'h0001_0000, 32'h0000_1000, 32'h0, 32'h0, 1'b1);
      write_order(ORDER_QUAD);
      send_point(32'h0001_0000, 32'h0001_0000, 32'h0000_1000, 32'h0000_2000,
                 32'h0000_3000, 1'b1);

      // Random passes with occasional order changes, some mid-pass
      random_points = 0;
      while (random_points < RANDOM_POINTS) begin
         pass_len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                : $urandom_range(1, 8);
         split = (pass_len > 1 && $urandom_range(0, 5) == 0)
                 ? $urandom_range(1, pass_len - 1) : 0;
         if ($urandom_range(0, 3) == 0)
            write_order(ORD_W'($urandom_range(0, 3)));
         for (int n = 0; n < pass_len; n++) begin
            if (split != 0 && n == split)
               write_order(ORD_W'($urandom_range(0, 3)));
            send_point(pick_bits(DENS_W), pick_bits(WGT_W), pick_bits(POS_W),
                       pick_bits(POS_W), pick_bits(POS_W), n == pass_len - 1);
         end
         random_points += pass_len;
      end

      settle();
      if (error_count == 0 && expected_moments.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/dmm_pkg.sv
design/dmm_queue.sv
design/dmm_front.sv
design/dmm_back.sv
design/density_multipole_moments.sv
verif/tb_density_multipole_moments.sv
